/* sv/qtva_pkg.sv */
package qtva_pkg;

  // Colour emitted while no colour has been loaded in the batch.
  localparam logic [31:0] WHITE = 32'hFFFF_FFFF;

  // Scale reset value, 1.0 in Q8.8.
  localparam logic [15:0] SCALE_ONE = 16'd256;

  // Value of the kind field that starts a new batch.
  localparam logic KIND_BEGIN = 1'b1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIM_MODE     = 3'd0,
    REG_OFFSET_X      = 3'd1,
    REG_OFFSET_Y      = 3'd2,
    REG_OFFSET_Z      = 3'd3,
    REG_SCALE_X       = 3'd4,
    REG_SCALE_Y       = 3'd5,
    REG_COLOR_DISABLE = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STEP_COPY0,
    STEP_COPY1,
    STEP_MAIN
  } emit_step_e;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic              load_tex;
    logic [15:0]       tex_u;
    logic [15:0]       tex_v;
    logic              load_color;
    logic [31:0]       color_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]       out_u;
    logic [15:0]       out_v;
    logic [31:0]       out_color;
    logic              run_last;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic              prim_mode;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic              color_disable;
  } cfg_t;

  // Everything the back end needs besides the position.
  typedef struct packed {
    logic [31:0] uv;
    logic [31:0] color;
    logic        tex_seen;
    logic        color_seen;
    logic        copies;
    logic        save;
    logic        slot;
    logic        overflow;
  } vtx_attr_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    vtx_attr_t         attr;
  } vtx_cmd_t;

endpackage

/* sv/qtva_fifo.sv */
module qtva_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(DEPTH))
    else $error("queue occupancy beyond its depth");

endmodule

/* sv/qtva_front.sv */
module qtva_front #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qtva_pkg::cfg_t     cfg_i,
  input  logic               acc_i,
  input  qtva_pkg::in_item_t item_i,
  output logic               cmd_valid_o,
  output qtva_pkg::vtx_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(CAPACITY) + 1;
  localparam logic [CntW-1:0] Limit = CntW'(CAPACITY - 1);

  logic [1:0]      phase_q, phase_d, phase_n;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_n;
  logic [31:0]     latched_uv_q, latched_uv_d;
  logic [31:0]     latched_col_q, latched_col_d;
  logic            tex_seen_q, tex_seen_d;
  logic            color_seen_q, color_seen_d;
  logic            is_begin, col_load, copies, ovf;

  always_comb begin
    is_begin      = (item_i.kind == qtva_pkg::KIND_BEGIN);
    col_load      = item_i.load_color && !cfg_i.color_disable;
    tex_seen_d    = tex_seen_q | item_i.load_tex;
    latched_uv_d  = item_i.load_tex ? {item_i.tex_u, item_i.tex_v} : latched_uv_q;
    color_seen_d  = color_seen_q | col_load;
    latched_col_d = col_load ? item_i.color_in : latched_col_q;
    phase_n       = phase_q + 2'd1;
    // The vertex that closes a quad is preceded by two copies.
    copies        = !cfg_i.prim_mode && (phase_n == 2'd0);
    cnt_n         = cnt_q + (copies ? CntW'(3) : CntW'(1));
    ovf           = (cnt_n[1:0] == 2'b00) && (cnt_n >= Limit);
    phase_d       = ovf ? 2'd0 : phase_n;
    cnt_d         = ovf ? '0 : cnt_n;
  end

  always_comb begin
    cmd_valid_o           = acc_i && !is_begin;
    cmd_o.pos_x           = item_i.pos_x;
    cmd_o.pos_y           = item_i.pos_y;
    cmd_o.pos_z           = item_i.pos_z;
    cmd_o.attr.uv         = tex_seen_d ? latched_uv_d : '0;
    cmd_o.attr.color      = color_seen_d ? latched_col_d : qtva_pkg::WHITE;
    cmd_o.attr.tex_seen   = tex_seen_d;
    cmd_o.attr.color_seen = color_seen_d;
    cmd_o.attr.copies     = copies;
    cmd_o.attr.save       = phase_n[0];
    cmd_o.attr.slot       = phase_n[1];
    cmd_o.attr.overflow   = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      cnt_q         <= '0;
      latched_uv_q  <= '0;
      latched_col_q <= qtva_pkg::WHITE;
      tex_seen_q    <= 1'b0;
      color_seen_q  <= 1'b0;
    end else if (acc_i) begin
      if (is_begin) begin
        phase_q      <= '0;
        cnt_q        <= '0;
        tex_seen_q   <= 1'b0;
        color_seen_q <= 1'b0;
      end else begin
        phase_q       <= phase_d;
        cnt_q         <= cnt_d;
        latched_uv_q  <= latched_uv_d;
        latched_col_q <= latched_col_d;
        tex_seen_q    <= tex_seen_d;
        color_seen_q  <= color_seen_d;
      end
    end
  end

  a_ovf_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && cmd_o.attr.overflow |=> (cnt_q == '0) && (phase_q == 2'd0))
    else $error("overflow did not restart the batch");

endmodule

/* sv/qtva_back.sv */
module qtva_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qtva_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  qtva_pkg::vtx_cmd_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                res_push_o,
  output qtva_pkg::out_item_t res_o,
  input  logic                res_full_i
);

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Floor division by 256 is an arithmetic shift; then clamp to 32 bits.
  function automatic logic [31:0] sat_q8(input logic signed [48:0] p);
    logic signed [48:0] sh;
    sh = p >>> 8;
    if (sh > 49'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (sh < -49'sd2147483648) begin
      return 32'h8000_0000;
    end
    return sh[31:0];
  endfunction

  // Stage 1: offset sums.
  logic                s1_v_q;
  logic signed [32:0]  s1_sx_q, s1_sy_q;
  logic [31:0]         s1_z_q;
  qtva_pkg::vtx_attr_t s1_attr_q;
  // Stage 2: products.
  logic                s2_v_q;
  logic signed [48:0]  s2_px_q, s2_py_q;
  logic [31:0]         s2_z_q;
  qtva_pkg::vtx_attr_t s2_attr_q;
  // Emit stage: final vertex, plays out copies then the vertex itself.
  logic                e_v_q;
  logic [31:0]         e_x_q, e_y_q, e_z_q;
  qtva_pkg::vtx_attr_t e_attr_q;
  qtva_pkg::emit_step_e e_step_q, e_step_d;

  logic [31:0] sv_x_q [2];
  logic [31:0] sv_y_q [2];
  logic [31:0] sv_z_q [2];
  logic [31:0] sv_uv_q [2];
  logic [31:0] sv_col_q [2];

  logic e_fire, e_last, e_free, s2_free, s1_free, slot;
  logic [31:0] uv_sel;

  assign e_fire    = e_v_q && !res_full_i;
  assign e_last    = (e_step_q == qtva_pkg::STEP_MAIN);
  assign e_free    = !e_v_q || (e_fire && e_last);
  assign s2_free   = !s2_v_q || e_free;
  assign s1_free   = !s1_v_q || s2_free;
  assign cmd_pop_o = cmd_valid_i && s1_free;

  // Next emit step.
  always_comb begin
    e_step_d = e_step_q;
    if (e_free) begin
      e_step_d = s2_attr_q.copies ? qtva_pkg::STEP_COPY0 : qtva_pkg::STEP_MAIN;
    end else if (e_fire) begin
      unique case (e_step_q)
        qtva_pkg::STEP_COPY0: e_step_d = qtva_pkg::STEP_COPY1;
        qtva_pkg::STEP_COPY1: e_step_d = qtva_pkg::STEP_MAIN;
        default:              e_step_d = qtva_pkg::STEP_MAIN;
      endcase
    end
  end

  // Result of the current emit step.
  always_comb begin
    slot       = (e_step_q == qtva_pkg::STEP_COPY1);
    res_push_o = e_fire;
    unique case (e_step_q)
      qtva_pkg::STEP_COPY0, qtva_pkg::STEP_COPY1: begin
        res_o.out_x     = sv_x_q[slot];
        res_o.out_y     = sv_y_q[slot];
        res_o.out_z     = sv_z_q[slot];
        uv_sel          = e_attr_q.tex_seen ? sv_uv_q[slot] : '0;
        res_o.out_color = e_attr_q.color_seen ? sv_col_q[slot] : qtva_pkg::WHITE;
        res_o.run_last  = 1'b0;
        res_o.overflow  = 1'b0;
      end
      default: begin
        res_o.out_x     = e_x_q;
        res_o.out_y     = e_y_q;
        res_o.out_z     = e_z_q;
        uv_sel          = e_attr_q.uv;
        res_o.out_color = e_attr_q.color;
        res_o.run_last  = 1'b1;
        res_o.overflow  = e_attr_q.overflow;
      end
    endcase
    res_o.out_u = uv_sel[31:16];
    res_o.out_v = uv_sel[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      e_v_q    <= 1'b0;
      e_step_q <= qtva_pkg::STEP_MAIN;
    end else begin
      if (s1_free) begin
        s1_v_q <= cmd_pop_o;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (e_free) begin
        e_v_q <= s2_v_q;
      end
      e_step_q <= e_step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_sx_q   <= 33'($signed(cmd_i.pos_x)) + 33'($signed(cfg_i.offset_x));
      s1_sy_q   <= 33'($signed(cmd_i.pos_y)) + 33'($signed(cfg_i.offset_y));
      s1_z_q    <= sat33(33'($signed(cmd_i.pos_z)) + 33'($signed(cfg_i.offset_z)));
      s1_attr_q <= cmd_i.attr;
    end
    if (s2_free) begin
      s2_px_q   <= 49'(s1_sx_q) * 49'($signed(cfg_i.scale_x));
      s2_py_q   <= 49'(s1_sy_q) * 49'($signed(cfg_i.scale_y));
      s2_z_q    <= s1_z_q;
      s2_attr_q <= s1_attr_q;
    end
    if (e_free) begin
      e_x_q    <= sat_q8(s2_px_q);
      e_y_q    <= sat_q8(s2_py_q);
      e_z_q    <= s2_z_q;
      e_attr_q <= s2_attr_q;
    end
    // A quad's first and third vertices are kept for the closing copies.
    if (e_fire && e_last && e_attr_q.save) begin
      sv_x_q[e_attr_q.slot]   <= e_x_q;
      sv_y_q[e_attr_q.slot]   <= e_y_q;
      sv_z_q[e_attr_q.slot]   <= e_z_q;
      sv_uv_q[e_attr_q.slot]  <= e_attr_q.uv;
      sv_col_q[e_attr_q.slot] <= e_attr_q.color;
    end
  end

  a_copy_only_when_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_v_q && (e_step_q == qtva_pkg::STEP_COPY0 || e_step_q == qtva_pkg::STEP_COPY1)
    |-> e_attr_q.copies)
    else $error("copy step on a vertex that closes no quad");

  a_copy_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire && (e_step_q == qtva_pkg::STEP_COPY0)
    |=> e_v_q && (e_step_q == qtva_pkg::STEP_COPY1))
    else $error("second copy did not follow the first");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_v_q && !e_free |=> e_v_q && $stable(e_x_q) && $stable(e_attr_q))
    else $error("stalled emit stage lost its vertex");

endmodule

/* sv/quad_to_triangle_vertex_assembler.sv */
// Quad-to-triangle vertex assembler. Vertex transactions are offset, scaled
// in x and y (Q16.16 positions, Q8.8 scales, floor rounding, saturation) and
// emitted with the batch's latched texture and colour; a begin transaction
// starts a new batch and produces nothing. In quad mode the vertex closing
// each quad is preceded by copies of the quad's first and third vertices,
// so the result stream is a triangle list; in pass-through mode every vertex
// gives exactly one result. A front end takes one transaction per cycle
// while the vertex queue has room, tracks the batch attributes and the
// emitted count, and hands vertices through a two-entry queue to a back
// end with a three-stage arithmetic pipeline (offset add, multiply, shift
// and clamp). The emit stage at the end of that pipeline writes one result
// per cycle into a two-entry result queue while that queue has room, and
// holds each vertex until its last result is written: one result per vertex
// in pass-through mode, three for a quad-closing vertex in quad mode, so six
// results per quad of four vertices. Configuration registers may be written
// only while the block holds no transaction in flight.
module quad_to_triangle_vertex_assembler #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  qtva_pkg::in_item_t                  in_item_i,
  output logic                                full,
  output qtva_pkg::out_item_t                 out_item_o,
  output logic                                empty,
  input  logic                                pop,
  input  logic                                cfg_we_i,
  input  logic [qtva_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qtva_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  qtva_pkg::cfg_t      cfg_q;
  qtva_pkg::vtx_cmd_t  fr_cmd, bk_cmd;
  qtva_pkg::out_item_t bk_res;
  logic                acc, fr_cmd_valid, cmd_q_full, cmd_q_empty, bk_pop;
  logic                res_push, res_full;

  // The queue between the two halves only fills with vertex transactions;
  // begin transactions are absorbed by the front end.
  assign acc = push && !full;
  assign full = cmd_q_full;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prim_mode     <= 1'b0;
      cfg_q.offset_x      <= '0;
      cfg_q.offset_y      <= '0;
      cfg_q.offset_z      <= '0;
      cfg_q.scale_x       <= qtva_pkg::SCALE_ONE;
      cfg_q.scale_y       <= qtva_pkg::SCALE_ONE;
      cfg_q.color_disable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (qtva_pkg::cfg_reg_e'(cfg_idx_i))
        qtva_pkg::REG_PRIM_MODE:     cfg_q.prim_mode     <= cfg_data_i[0];
        qtva_pkg::REG_OFFSET_X:      cfg_q.offset_x      <= cfg_data_i;
        qtva_pkg::REG_OFFSET_Y:      cfg_q.offset_y      <= cfg_data_i;
        qtva_pkg::REG_OFFSET_Z:      cfg_q.offset_z      <= cfg_data_i;
        qtva_pkg::REG_SCALE_X:       cfg_q.scale_x       <= cfg_data_i[15:0];
        qtva_pkg::REG_SCALE_Y:       cfg_q.scale_y       <= cfg_data_i[15:0];
        qtva_pkg::REG_COLOR_DISABLE: cfg_q.color_disable <= cfg_data_i[0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  qtva_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .acc_i       (acc),
    .item_i      (in_item_i),
    .cmd_valid_o (fr_cmd_valid),
    .cmd_o       (fr_cmd)
  );

  qtva_fifo #(
    .DEPTH (2),
    .T     (qtva_pkg::vtx_cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_cmd_valid),
    .data_i  (fr_cmd),
    .full_o  (cmd_q_full),
    .pop_i   (bk_pop),
    .data_o  (bk_cmd),
    .empty_o (cmd_q_empty)
  );

  qtva_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_q_empty),
    .cmd_i       (bk_cmd),
    .cmd_pop_o   (bk_pop),
    .res_push_o  (res_push),
    .res_o       (bk_res),
    .res_full_i  (res_full)
  );

  qtva_fifo #(
    .DEPTH (2),
    .T     (qtva_pkg::out_item_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (bk_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule
